>>> sv/dedf_pkg.sv
// ----------------------------------------------------------------------------
// Digitizer event deframer package
// Beat payload types and fixed codes shared by the deframer modules.
// ----------------------------------------------------------------------------
package dedf_pkg;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_RECORD     = 2'd0,
    KIND_SAMPLE     = 2'd1,
    KIND_BAD_TYPE   = 2'd2,
    KIND_BAD_SELECT = 2'd3
  } kind_t;

  // Event type codes as carried in the header.
  localparam logic [1:0] TYPE_NONE = 2'd0;
  localparam logic [1:0] TYPE_DPP  = 2'd1;
  localparam logic [1:0] TYPE_WAVE = 2'd2;

  // The only extra-select code that the deframer understands.
  localparam logic [15:0] EXTRA_SELECT_STD = 16'd2;

  // Split of the extras low word.
  localparam int FINE_WIDTH  = 10;
  localparam int FLAGS_WIDTH = 6;

  typedef struct packed {
    logic [15:0] word_in;
  } word_t;

  typedef struct packed {
    kind_t                    kind;
    logic [1:0]               event_type;
    logic [31:0]              channel;
    logic [31:0]              time_tag;
    logic [15:0]              extended_time;
    logic [FINE_WIDTH-1:0]    fine_time;
    logic [FLAGS_WIDTH-1:0]   config_flags;
    logic [15:0]              short_charge;
    logic [15:0]              long_charge;
    logic [31:0]              sample_count;
    logic [15:0]              sample_value;
    logic                     last;
  } result_t;

  // Word held in the input register.
  typedef struct packed {
    logic        valid;
    logic [15:0] word;
  } stage_t;

  // Result offered by the parser to the output register.
  typedef struct packed {
    logic    valid;
    result_t data;
  } res_beat_t;

endpackage

>>> sv/dedf_stream_if.sv
// ----------------------------------------------------------------------------
// Deframer stream interface
// Valid/ready channel carrying one payload per beat.
// ----------------------------------------------------------------------------
interface dedf_stream_if #(
  parameter type payload_t = logic
);

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);

endinterface

>>> sv/dedf_in_reg.sv
// ----------------------------------------------------------------------------
// Deframer input register
// Captures one word beat per cycle whenever the parser stage can move on.
// ----------------------------------------------------------------------------
module dedf_in_reg (
  input  logic               clk,
  input  logic               rst,
  dedf_stream_if.sink        words,
  input  logic               advance,
  output dedf_pkg::stage_t   stage
);
  import dedf_pkg::*;

  logic        valid;
  logic [15:0] word;

  // The register may be refilled when empty or when its word moves on.
  assign words.ready = !valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (words.ready) begin
      valid <= words.valid;
    end
    if (words.ready && words.valid) begin
      word <= words.data.word_in;
    end
  end

  assign stage.valid = valid;
  assign stage.word  = word;

endmodule

>>> sv/dedf_parser.sv
// ----------------------------------------------------------------------------
// Deframer parser
// Word phase sequencer, header field capture and result formation.
// ----------------------------------------------------------------------------
module dedf_parser (
  input  logic                clk,
  input  logic                rst,
  input  dedf_pkg::stage_t    stage,
  input  logic                advance,
  output dedf_pkg::res_beat_t beat
);
  import dedf_pkg::*;

  typedef enum logic [4:0] {
    PH_SIZE_LO, PH_SIZE_HI, PH_TYPE_LO, PH_TYPE_HI, PH_CHAN_LO, PH_CHAN_HI,
    PH_TIME_LO, PH_TIME_HI, PH_SELECT, PH_EXTRA_LO, PH_EXTRA_HI, PH_SHORT,
    PH_LONG, PH_SKIP_A, PH_SKIP_B, PH_COUNT_LO, PH_COUNT_HI, PH_SAMPLE
  } phase_t;

  phase_t                 phase, phase_next;
  logic [15:0]            low_half, low_half_next;
  logic [1:0]             held_type, held_type_next;
  logic [31:0]            held_channel, held_channel_next;
  logic [31:0]            held_time_tag, held_time_tag_next;
  logic [15:0]            held_extended_time, held_extended_time_next;
  logic [FINE_WIDTH-1:0]  held_fine_time, held_fine_time_next;
  logic [FLAGS_WIDTH-1:0] held_flags, held_flags_next;
  logic [15:0]            held_short_charge, held_short_charge_next;
  logic [15:0]            held_long_charge, held_long_charge_next;
  logic [31:0]            samples_left, samples_left_next;
  logic                   halted, halted_next;

  logic                   fire;
  logic [31:0]            joined;
  logic [15:0]            w;

  assign fire   = stage.valid && advance && !halted;
  assign w      = stage.word;
  assign joined = {w, low_half};

  // Next state and the result caused by the word in the input register.
  always_comb begin
    phase_next              = phase;
    low_half_next           = low_half;
    held_type_next          = held_type;
    held_channel_next       = held_channel;
    held_time_tag_next      = held_time_tag;
    held_extended_time_next = held_extended_time;
    held_fine_time_next     = held_fine_time;
    held_flags_next         = held_flags;
    held_short_charge_next  = held_short_charge;
    held_long_charge_next   = held_long_charge;
    samples_left_next       = samples_left;
    halted_next             = halted;
    beat                    = '0;

    if (fire) begin
      unique case (phase)
        PH_SIZE_LO: begin
          held_type_next          = TYPE_NONE;
          held_channel_next       = '0;
          held_time_tag_next      = '0;
          held_extended_time_next = '0;
          held_fine_time_next     = '0;
          held_flags_next         = '0;
          held_short_charge_next  = '0;
          held_long_charge_next   = '0;
          phase_next              = PH_SIZE_HI;
        end
        PH_SIZE_HI: phase_next = PH_TYPE_LO;
        PH_TYPE_LO, PH_CHAN_LO, PH_TIME_LO, PH_COUNT_LO: begin
          low_half_next = w;
          phase_next    = phase_t'(phase + 5'd1);
        end
        PH_TYPE_HI: begin
          if (joined == 32'(TYPE_DPP) || joined == 32'(TYPE_WAVE)) begin
            held_type_next = joined[1:0];
          end else begin
            held_type_next = TYPE_NONE;
          end
          phase_next = PH_CHAN_LO;
        end
        PH_CHAN_HI: begin
          held_channel_next = joined;
          phase_next        = PH_TIME_LO;
        end
        PH_TIME_HI: begin
          held_time_tag_next = joined;
          if (held_type == TYPE_DPP) begin
            phase_next = PH_SELECT;
          end else if (held_type == TYPE_WAVE) begin
            phase_next = PH_COUNT_LO;
          end else begin
            halted_next     = 1'b1;
            beat.valid      = 1'b1;
            beat.data.kind  = KIND_BAD_TYPE;
          end
        end
        PH_SELECT: begin
          if (w != EXTRA_SELECT_STD) begin
            halted_next    = 1'b1;
            beat.valid     = 1'b1;
            beat.data.kind = KIND_BAD_SELECT;
          end else begin
            phase_next = PH_EXTRA_LO;
          end
        end
        PH_EXTRA_LO: begin
          held_fine_time_next = w[FINE_WIDTH-1:0];
          held_flags_next     = w[15:FINE_WIDTH];
          phase_next          = PH_EXTRA_HI;
        end
        PH_EXTRA_HI: begin
          held_extended_time_next = w;
          phase_next              = PH_SHORT;
        end
        PH_SHORT: begin
          held_short_charge_next = w;
          phase_next             = PH_LONG;
        end
        PH_LONG: begin
          held_long_charge_next = w;
          phase_next            = PH_SKIP_A;
        end
        PH_SKIP_A: phase_next = PH_SKIP_B;
        PH_SKIP_B: phase_next = PH_COUNT_LO;
        PH_COUNT_HI: begin
          samples_left_next       = joined;
          beat.valid              = 1'b1;
          beat.data.kind          = KIND_RECORD;
          beat.data.event_type    = held_type;
          beat.data.channel       = held_channel;
          beat.data.time_tag      = held_time_tag;
          beat.data.extended_time = held_extended_time;
          beat.data.fine_time     = held_fine_time;
          beat.data.config_flags  = held_flags;
          beat.data.short_charge  = held_short_charge;
          beat.data.long_charge   = held_long_charge;
          beat.data.sample_count  = joined;
          beat.data.last          = (joined == '0);
          phase_next              = (joined == '0) ? PH_SIZE_LO : PH_SAMPLE;
        end
        PH_SAMPLE: begin
          samples_left_next      = samples_left - 32'd1;
          beat.valid             = 1'b1;
          beat.data.kind         = KIND_SAMPLE;
          beat.data.sample_value = w;
          beat.data.last         = (samples_left == 32'd1);
          if (samples_left == 32'd1) begin
            phase_next = PH_SIZE_LO;
          end
        end
        default: phase_next = PH_SIZE_LO;
      endcase
    end
  end

  // Sequencer and held header fields.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= PH_SIZE_LO;
      low_half           <= '0;
      held_type          <= TYPE_NONE;
      held_channel       <= '0;
      held_time_tag      <= '0;
      held_extended_time <= '0;
      held_fine_time     <= '0;
      held_flags         <= '0;
      held_short_charge  <= '0;
      held_long_charge   <= '0;
      samples_left       <= '0;
      halted             <= 1'b0;
    end else begin
      phase              <= phase_next;
      low_half           <= low_half_next;
      held_type          <= held_type_next;
      held_channel       <= held_channel_next;
      held_time_tag      <= held_time_tag_next;
      held_extended_time <= held_extended_time_next;
      held_fine_time     <= held_fine_time_next;
      held_flags         <= held_flags_next;
      held_short_charge  <= held_short_charge_next;
      held_long_charge   <= held_long_charge_next;
      samples_left       <= samples_left_next;
      halted             <= halted_next;
    end
  end

  // Once halted, nothing more is produced.
  a_halt_silent: assert property (@(posedge clk) disable iff (rst)
    halted |-> !beat.valid)
    else $error("result produced while halted");

  // The sample phase is only entered with samples still to come.
  a_samples_pending: assert property (@(posedge clk) disable iff (rst)
    phase == PH_SAMPLE |-> samples_left != '0)
    else $error("sample phase with no samples left");

  // An error result always halts the block on the next edge.
  a_error_halts: assert property (@(posedge clk) disable iff (rst)
    beat.valid && (beat.data.kind == KIND_BAD_TYPE ||
                   beat.data.kind == KIND_BAD_SELECT) |=> halted)
    else $error("error result without halting");

  // A record marked last carries a zero sample count.
  a_empty_record: assert property (@(posedge clk) disable iff (rst)
    beat.valid && beat.data.kind == KIND_RECORD && beat.data.last
      |-> beat.data.sample_count == '0)
    else $error("last record with samples pending");

endmodule

>>> sv/dedf_out_reg.sv
// ----------------------------------------------------------------------------
// Deframer output register
// Holds one result beat until the sink takes it.
// ----------------------------------------------------------------------------
module dedf_out_reg (
  input  logic                clk,
  input  logic                rst,
  input  dedf_pkg::res_beat_t beat,
  output logic                advance,
  dedf_stream_if.source       results
);
  import dedf_pkg::*;

  logic    valid;
  result_t data;

  // The register can load a new beat when empty or being emptied.
  assign advance = !valid || results.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (advance) begin
      valid <= beat.valid;
    end
    if (advance && beat.valid) begin
      data <= beat.data;
    end
  end

  assign results.valid = valid;
  assign results.data  = data;

endmodule

>>> sv/digitizer_event_deframer.sv
// ----------------------------------------------------------------------------
// Digitizer event deframer
// Splits a 16-bit word stream into event records and waveform samples.
//
//   Channel  Role    Payload
//   words    sink    word_in, one 16-bit word of the event stream
//   results  source  kind, header fields, sample_count, sample_value, last
//
// A new word is taken every cycle while the result register is free or
// being emptied. A word reaches results through the input register, then
// the result register.
// Synchronous reset returns the sequencer to the first header word and
// clears the halt that follows a bad type or bad extra select.
// A stall on results holds the result register and back-pressures words.
// ----------------------------------------------------------------------------
module digitizer_event_deframer (
  input  logic   clk,
  input  logic   rst,
  dedf_stream_if.sink   words,
  dedf_stream_if.source results
);
  import dedf_pkg::*;

  stage_t    stage;
  res_beat_t beat;
  logic      advance;

  dedf_in_reg u_in_reg (
    .clk     (clk),
    .rst     (rst),
    .words   (words),
    .advance (advance),
    .stage   (stage)
  );

  dedf_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .stage   (stage),
    .advance (advance),
    .beat    (beat)
  );

  dedf_out_reg u_out_reg (
    .clk     (clk),
    .rst     (rst),
    .beat    (beat),
    .advance (advance),
    .results (results)
  );

endmodule

>>> tb/dedf_checker.sv
// ----------------------------------------------------------------------------
// Digitizer event deframer checker
// Watches the word and result channels, rebuilds the event records and
// samples that each accepted word should give, and compares every accepted
// result beat with the oldest one still outstanding, field by field.
// ----------------------------------------------------------------------------
module dedf_checker
  import dedf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        word_valid,
  input  logic        word_ready,
  input  logic [15:0] word,
  input  logic        result_valid,
  input  logic        result_ready,
  input  result_t     result,
  output int          fail_count,
  output int          pending
);

  // Position within the event that the next word fills.
  typedef enum logic [4:0] {
    HDR_SIZE_LO, HDR_SIZE_HI, HDR_TYPE_LO, HDR_TYPE_HI,
    HDR_CHAN_LO, HDR_CHAN_HI, HDR_TIME_LO, HDR_TIME_HI,
    DPP_SELECT, DPP_EXTRAS_LO, DPP_EXTRAS_HI, DPP_SHORT, DPP_LONG,
    DPP_PAD_A, DPP_PAD_B, CNT_LO, CNT_HI, SAMPLES
  } phase_t;

  phase_t      phase;
  logic [15:0] low_word;
  logic [1:0]  ev_type;
  logic [31:0] chan;
  logic [31:0] tag;
  logic [15:0] ext_time;
  logic [9:0]  fine;
  logic [5:0]  flags;
  logic [15:0] short_q;
  logic [15:0] long_q;
  logic [31:0] remaining;
  logic        stopped;

  result_t deframed_q[$];

  // Advances the event parse by one word; returns 1 when the word yields a
  // result beat, which is then left in r.
  function automatic bit deframe_word(input logic [15:0] w, output result_t r);
    logic [31:0] joined;
    r      = '0;
    joined = {w, low_word};
    if (stopped) return 1'b0;
    case (phase)
      HDR_SIZE_LO: begin
        ev_type  = TYPE_NONE;
        chan     = '0;
        tag      = '0;
        ext_time = '0;
        fine     = '0;
        flags    = '0;
        short_q  = '0;
        long_q   = '0;
        phase    = HDR_SIZE_HI;
      end
      HDR_SIZE_HI: phase = HDR_TYPE_LO;
      HDR_TYPE_LO: begin
        low_word = w;
        phase    = HDR_TYPE_HI;
      end
      HDR_TYPE_HI: begin
        if (joined == 32'(TYPE_DPP) || joined == 32'(TYPE_WAVE)) ev_type = joined[1:0];
        else ev_type = TYPE_NONE;
        phase = HDR_CHAN_LO;
      end
      HDR_CHAN_LO: begin
        low_word = w;
        phase    = HDR_CHAN_HI;
      end
      HDR_CHAN_HI: begin
        chan  = joined;
        phase = HDR_TIME_LO;
      end
      HDR_TIME_LO: begin
        low_word = w;
        phase    = HDR_TIME_HI;
      end
      HDR_TIME_HI: begin
        tag = joined;
        if (ev_type == TYPE_DPP) begin
          phase = DPP_SELECT;
        end else if (ev_type == TYPE_WAVE) begin
          phase = CNT_LO;
        end else begin
          // Unknown event type: report it and stop parsing for good.
          stopped = 1'b1;
          r.kind  = KIND_BAD_TYPE;
          return 1'b1;
        end
      end
      DPP_SELECT: begin
        if (w != EXTRA_SELECT_STD) begin
          stopped = 1'b1;
          r.kind  = KIND_BAD_SELECT;
          return 1'b1;
        end
        phase = DPP_EXTRAS_LO;
      end
      DPP_EXTRAS_LO: begin
        fine  = w[9:0];
        flags = w[15:10];
        phase = DPP_EXTRAS_HI;
      end
      DPP_EXTRAS_HI: begin
        ext_time = w;
        phase    = DPP_SHORT;
      end
      DPP_SHORT: begin
        short_q = w;
        phase   = DPP_LONG;
      end
      DPP_LONG: begin
        long_q = w;
        phase  = DPP_PAD_A;
      end
      DPP_PAD_A: phase = DPP_PAD_B;
      DPP_PAD_B: phase = CNT_LO;
      CNT_LO: begin
        low_word = w;
        phase    = CNT_HI;
      end
      CNT_HI: begin
        remaining       = joined;
        r.kind          = KIND_RECORD;
        r.event_type    = ev_type;
        r.channel       = chan;
        r.time_tag      = tag;
        r.extended_time = ext_time;
        r.fine_time     = fine;
        r.config_flags  = flags;
        r.short_charge  = short_q;
        r.long_charge   = long_q;
        r.sample_count  = joined;
        r.last          = (joined == '0);
        phase           = (joined == '0) ? HDR_SIZE_LO : SAMPLES;
        return 1'b1;
      end
      SAMPLES: begin
        remaining      = remaining - 32'd1;
        r.kind         = KIND_SAMPLE;
        r.sample_value = w;
        r.last         = (remaining == '0);
        if (remaining == '0) phase = HDR_SIZE_LO;
        return 1'b1;
      end
      default: phase = HDR_SIZE_LO;
    endcase
    return 1'b0;
  endfunction

  task automatic report(input string field, input logic [31:0] want, input logic [31:0] got);
    $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
    fail_count++;
  endtask

  task automatic compare_fields(input result_t got, input result_t want);
    if (got.kind !== want.kind) report("kind", want.kind, got.kind);
    if (got.event_type !== want.event_type) report("event_type", want.event_type, got.event_type);
    if (got.channel !== want.channel) report("channel", want.channel, got.channel);
    if (got.time_tag !== want.time_tag) report("time_tag", want.time_tag, got.time_tag);
    if (got.extended_time !== want.extended_time)
      report("extended_time", want.extended_time, got.extended_time);
    if (got.fine_time !== want.fine_time) report("fine_time", want.fine_time, got.fine_time);
    if (got.config_flags !== want.config_flags)
      report("config_flags", want.config_flags, got.config_flags);
    if (got.short_charge !== want.short_charge)
      report("short_charge", want.short_charge, got.short_charge);
    if (got.long_charge !== want.long_charge)
      report("long_charge", want.long_charge, got.long_charge);
    if (got.sample_count !== want.sample_count)
      report("sample_count", want.sample_count, got.sample_count);
    if (got.sample_value !== want.sample_value)
      report("sample_value", want.sample_value, got.sample_value);
    if (got.last !== want.last) report("last", want.last, got.last);
  endtask

  // Predict on accepted words, compare on accepted results.
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      phase     = HDR_SIZE_LO;
      low_word  = '0;
      ev_type   = TYPE_NONE;
      chan      = '0;
      tag       = '0;
      ext_time  = '0;
      fine      = '0;
      flags     = '0;
      short_q   = '0;
      long_q    = '0;
      remaining = '0;
      stopped   = 1'b0;
      deframed_q.delete();
    end else begin
      if (word_valid && word_ready && deframe_word(word, want)) deframed_q = {deframed_q, want};
      if (result_valid && result_ready) begin
        if (deframed_q.size() == 0) begin
          $error("result beat of kind %0d arrived with nothing outstanding", result.kind);
          fail_count++;
        end else begin
          compare_fields(result, deframed_q.pop_front());
        end
      end
    end
    pending = deframed_q.size();
  end

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// Digitizer event deframer testbench
// Feeds hand-built events with extreme field values, then about 1500 words of
// well-formed DPP and waveform events with random content, and finally one
// malformed event (a bad type or a bad extra select, chosen at random)
// followed by words that must be ignored. Both channels idle at random; a
// checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;
  import dedf_pkg::*;

  localparam int WORD_TARGET    = 1500;
  localparam int CALM_FROM      = 1200;
  localparam int CALM_TO        = 2400;
  localparam int WATCHDOG_LIMIT = 2000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   cycle;
  int   words_sent;
  int   quiet_cycles;
  int   fail_count;
  int   pending;

  always #6 clk = ~clk;

  dedf_stream_if #(.payload_t(word_t))   words_if ();
  dedf_stream_if #(.payload_t(result_t)) results_if ();

  digitizer_event_deframer i_dut (
    .clk     (clk),
    .rst     (rst),
    .words   (words_if),
    .results (results_if)
  );

  dedf_checker i_checker (
    .clk          (clk),
    .rst          (rst),
    .word_valid   (words_if.valid),
    .word_ready   (words_if.ready),
    .word         (words_if.data.word_in),
    .result_valid (results_if.valid),
    .result_ready (results_if.ready),
    .result       (results_if.data),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  // Random idling on either side, switched off for one stretch of the run.
  function automatic bit take_break();
    if (cycle >= CALM_FROM && cycle < CALM_TO) return 1'b0;
    return $urandom_range(99) < 37;
  endfunction

  function automatic logic [15:0] rand16();
    case ($urandom_range(7))
      0:       return 16'h0000;
      1:       return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] rand32();
    case ($urandom_range(7))
      0:       return 32'h0000_0000;
      1:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_count();
    case ($urandom_range(9))
      0:       return 32'd0;
      1:       return 32'd1;
      9:       return 32'($urandom_range(40, 10));
      default: return 32'($urandom_range(8, 2));
    endcase
  endfunction

  // Result side back-pressure.
  always @(posedge clk) begin
    cycle++;
    results_if.ready <= rst ? 1'b0 : !take_break();
  end

  // Watchdog on cycles with no beat on either channel.
  always @(posedge clk) begin
    if (rst || (words_if.valid && words_if.ready) || (results_if.valid && results_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  task automatic send_word(input logic [15:0] w);
    while (take_break()) begin
      words_if.valid <= 1'b0;
      @(posedge clk);
    end
    words_if.valid <= 1'b1;
    words_if.data  <= word_t'(w);
    @(posedge clk);
    while (!words_if.ready) @(posedge clk);
    words_sent++;
  endtask

  // 32-bit quantities go low word first.
  task automatic send_pair(input logic [31:0] v);
    send_word(v[15:0]);
    send_word(v[31:16]);
  endtask

  task automatic send_random_event(input logic [31:0] count);
    bit dpp;
    dpp = $urandom_range(1);
    send_pair(rand32());
    send_pair(dpp ? 32'(TYPE_DPP) : 32'(TYPE_WAVE));
    send_pair(rand32());
    send_pair(rand32());
    if (dpp) begin
      send_word(EXTRA_SELECT_STD);
      repeat (6) send_word(rand16());
    end
    send_pair(count);
    for (int unsigned i = 0; i < count; i++) send_word(rand16());
  endtask

  // A malformed event that halts the block, then words it must ignore.
  task automatic send_broken_event();
    logic [31:0] bad_type;
    logic [15:0] bad_select;
    send_pair(rand32());
    if ($urandom_range(1)) begin
      case ($urandom_range(3))
        0:       bad_type = 32'h0000_0000;
        1:       bad_type = 32'h0000_0003;
        2:       bad_type = 32'hffff_ffff;
        default: bad_type = 32'h0001_0000 | 32'(TYPE_DPP);
      endcase
      send_pair(bad_type);
      send_pair(rand32());
      send_pair(rand32());
    end else begin
      bad_select = rand16();
      if (bad_select == EXTRA_SELECT_STD) bad_select = ~bad_select;
      send_pair(32'(TYPE_DPP));
      send_pair(rand32());
      send_pair(rand32());
      send_word(bad_select);
    end
    repeat (6) send_word(rand16());
  endtask

  initial begin
    words_if.valid   <= 1'b0;
    words_if.data    <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // DPP event with every field at an extreme and no samples.
    send_pair(32'hffff_ffff);
    send_pair(32'(TYPE_DPP));
    send_pair(32'hffff_ffff);
    send_pair(32'h0000_0000);
    send_word(EXTRA_SELECT_STD);
    send_word(16'hffff);
    send_word(16'hffff);
    send_word(16'hffff);
    send_word(16'h0000);
    send_word(16'hffff);
    send_word(16'h0000);
    send_pair(32'd0);

    // Waveform event with a single full-scale sample.
    send_pair(32'h0000_0000);
    send_pair(32'(TYPE_WAVE));
    send_pair(32'h0000_0000);
    send_pair(32'hffff_ffff);
    send_pair(32'd1);
    send_word(16'hffff);

    while (words_sent < WORD_TARGET) send_random_event(rand_count());

    send_broken_event();
    words_if.valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> digitizer_event_deframer.f
sv/dedf_pkg.sv
sv/dedf_stream_if.sv
sv/dedf_in_reg.sv
sv/dedf_parser.sv
sv/dedf_out_reg.sv
sv/digitizer_event_deframer.sv
tb/dedf_checker.sv
tb/tb_top.sv
